### rtl/core/bnfa_pkg.sv
// ---------------------------------------------------------------------------
// bnfa_pkg
// Shared constants, codes and helpers for the bitmap next-fit allocator.
// ---------------------------------------------------------------------------
package bnfa_pkg;

  localparam int BITMAP_BYTES_DEF = 512;

  localparam int SLOT_W   = 12;  // granted_slot / slot_index width
  localparam int COUNT_W  = 13;  // free_slots width
  localparam int IN_W     = 16;  // s_tdata width
  localparam int OUT_W    = 32;  // m_tdata width
  localparam int OUT_PAD  = OUT_W - COUNT_W - 1 - SLOT_W;

  localparam logic [7:0] FULL_BYTE = 8'hFF;
  localparam logic [7:0] TOP_BIT   = 8'h80;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Position of the most significant clear bit, counted from the MSB.
  // Seven when the top seven bits are all set.
  function automatic logic [2:0] first_clear(input logic [7:0] b);
    logic [2:0] idx;
    idx = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (!b[7 - i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/core/bnfa_ram.sv
// ---------------------------------------------------------------------------
// bnfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bnfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/bitmap_next_fit_allocator.sv
// ---------------------------------------------------------------------------
// bitmap_next_fit_allocator
// Next-fit slot allocator over a byte-wide occupancy bitmap held in RAM.
// ---------------------------------------------------------------------------
// One transaction on the slave side is one request: tuser selects allocate
// (0) or free (1), tdata carries the slot to free. Each request returns one
// transaction on the master side with the granted slot, a full flag and the
// free count after the request. The bitmap lives in a single RAM, one byte
// per row, MSB-first (slot s is bit 7-s%8 of row s/8). A small sequencer
// walks it one row at a time through the RAM's registered read port and
// does a read-modify-write on the row it settles on. The block takes one
// request at a time; s_tready is high only while the sequencer is idle.
// An allocate scans row by row, starting at the row of the last granted
// slot and wrapping, until it finds a row with room or has visited every
// row; an allocate with a zero free count and a free of a slot beyond
// capacity go straight to the result.
// The master side has its own output register, so a new request is taken
// while the previous result waits for m_tready. After reset a clearing pass
// writes zero to every row, with s_tready held low.
// ---------------------------------------------------------------------------
module bitmap_next_fit_allocator
  import bnfa_pkg::*;
#(
  parameter int BITMAP_BYTES = BITMAP_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // [11:0] slot_index, [15:12] zero
  input  logic             s_tuser,   // [0] mode
  // result channel
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // [11:0] granted_slot, [12] status,
                                      // [25:13] free_slots, [31:26] zero
);

  localparam int AW  = $clog2(BITMAP_BYTES);        // row address width
  localparam int CAP = BITMAP_BYTES * 8;            // slot capacity
  localparam int CW  = $clog2(CAP + 1);             // free counter width
  localparam logic [AW-1:0] LAST_ROW = AW'(BITMAP_BYTES - 1);

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b0000001,  // post-reset sweep writing zeros
    ST_IDLE      = 7'b0000010,  // waiting for a request
    ST_ALLOC_RD  = 7'b0000100,  // row read issued at pos
    ST_ALLOC_CHK = 7'b0001000,  // row data back; test for room
    ST_FREE_RD   = 7'b0010000,
    ST_FREE_CHK  = 7'b0100000,  // clear the bit, bump the count
    ST_FINISH    = 7'b1000000   // hand result to the output register
  } state_t;

  state_t              state;
  logic [AW-1:0]       pos;       // current row; also the clear-sweep address
  logic [AW-1:0]       tries;     // rows already found full in this scan
  logic [AW-1:0]       hint;      // row of the last granted slot
  logic [CW-1:0]       count;     // free slot count
  logic [2:0]          bit_sel;   // bit of the slot being freed
  logic [SLOT_W-1:0]   res_slot;
  logic                res_status;

  // RAM ports
  logic                ram_we;
  logic [7:0]          ram_wdata;
  logic [7:0]          rd_data;

  // request decode
  logic [8:0]          in_row;
  logic                in_range;
  logic                row_has_room;
  logic [2:0]          clear_idx;

  assign in_row       = s_tdata[SLOT_W-1:3];
  assign in_range     = int'(in_row) < BITMAP_BYTES;
  assign row_has_room = (rd_data != FULL_BYTE);
  assign clear_idx    = first_clear(rd_data);

  assign s_tready = (state == ST_IDLE);

  // Write side of the RAM: clear sweep, set on grant, clear on free.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_ALLOC_CHK: begin
        ram_we    = row_has_room;
        ram_wdata = rd_data | (TOP_BIT >> clear_idx);
      end
      ST_FREE_CHK: begin
        ram_we    = 1'b1;
        ram_wdata = rd_data & ~(TOP_BIT >> bit_sel);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bnfa_ram #(
    .WIDTH (8),
    .DEPTH (BITMAP_BYTES)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      pos      <= '0;
      hint     <= '0;
      count    <= CW'(CAP);
      m_tvalid <= 1'b0;
    end else begin
      // in ST_FINISH the output register is reloaded below instead
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (pos == LAST_ROW) begin
            pos   <= '0;
            state <= ST_IDLE;
          end else begin
            pos <= pos + AW'(1);
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            res_slot   <= '0;
            res_status <= STATUS_DONE;
            tries      <= '0;
            if (s_tuser == MODE_FREE) begin
              pos     <= AW'(in_row);
              bit_sel <= s_tdata[2:0];
              // out-of-range free leaves the bitmap and the count alone
              state   <= in_range ? ST_FREE_RD : ST_FINISH;
            end else if (count == '0) begin
              res_status <= STATUS_FULL;
              state      <= ST_FINISH;
            end else begin
              pos   <= hint;
              state <= ST_ALLOC_RD;
            end
          end
        end
        ST_ALLOC_RD: begin
          state <= ST_ALLOC_CHK;
        end
        ST_ALLOC_CHK: begin
          if (row_has_room) begin
            hint     <= pos;
            count    <= count - CW'(1);
            res_slot <= SLOT_W'({pos, clear_idx});
            state    <= ST_FINISH;
          end else if (tries == LAST_ROW) begin
            // every row visited and full, although the count said otherwise
            res_status <= STATUS_FULL;
            state      <= ST_FINISH;
          end else begin
            tries <= tries + AW'(1);
            pos   <= (pos == LAST_ROW) ? '0 : pos + AW'(1);
            state <= ST_ALLOC_RD;
          end
        end
        ST_FREE_RD: begin
          state <= ST_FREE_CHK;
        end
        ST_FREE_CHK: begin
          // freeing a clear slot still counts, up to capacity
          if (count != CW'(CAP)) begin
            count <= count + CW'(1);
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {OUT_PAD'(0), COUNT_W'(count), res_status, res_slot};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/bnfa_checker.sv
// ---------------------------------------------------------------------------
// bnfa_checker
// Port-level assertions for the bitmap next-fit allocator, bound to the top.
// ---------------------------------------------------------------------------
module bnfa_checker
  import bnfa_pkg::*;
#(
  parameter int BITMAP_BYTES = BITMAP_BYTES_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  localparam int CAP = BITMAP_BYTES * 8;
  localparam bit CAP_FITS = (CAP < (1 << COUNT_W));

  logic [COUNT_W-1:0] out_count;
  assign out_count = m_tdata[OUT_W-OUT_PAD-1:SLOT_W+1];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one request at a time: ready drops right after a transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // a full answer never carries a slot
  a_full_no_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[SLOT_W] == STATUS_FULL |-> m_tdata[SLOT_W-1:0] == '0)
    else $error("slot granted with full status");

  // free count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !CAP_FITS || int'(out_count) <= CAP)
    else $error("free count above capacity");

  // no result is valid right after reset
  a_no_spurious: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result right after reset");

endmodule

bind bitmap_next_fit_allocator bnfa_checker #(
  .BITMAP_BYTES (BITMAP_BYTES)
) u_bnfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
